@@ design/prbase_pkg.sv @@
package prbase_pkg;

   // CORDIC arctangent table length and step index width
   localparam int AtanLen = 24;
   localparam int StepW   = 5;

   // gain-compensated one in Q2.30
   localparam logic signed [39:0] CordicGain = 40'sh0026DD3B6A;
   localparam logic signed [15:0] Q14One     = 16'sd16384;

   // datapath operations issued by the controller states; OP_STEP serves all three CORDIC run states
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PROD,
      OP_VEC_INIT,
      OP_STEP,
      OP_YAW,
      OP_ORG_INIT,
      OP_ORG_STORE,
      OP_POS_MUL,
      OP_POS_SUM,
      OP_HALF_INIT,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [StepW-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic captured;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_VINIT,
      S_VRUN,
      S_YAW,
      S_OINIT,
      S_ORUN,
      S_OSTORE,
      S_PMUL,
      S_PSUM,
      S_HINIT,
      S_HRUN,
      S_OUT
   } state_type;

   // atan(2^-i), full circle is 2^32
   function automatic logic [31:0] atan_entry(input logic [StepW-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

@@ design/prbase_ctrl.sv @@
module prbase_ctrl import prbase_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
   localparam logic [StepW-1:0] LastStep = StepW'(NSteps - 1);

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             valid_ff, valid_in;
   logic             out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_PROD;
         S_PROD:   state_in = S_VINIT;
         S_VINIT:  state_in = S_VRUN;
         S_VRUN:   if (step_ff == LastStep) state_in = S_YAW;
         S_YAW:    state_in = status.captured ? S_PMUL : S_OINIT;
         S_OINIT:  state_in = S_ORUN;
         S_ORUN:   if (step_ff == LastStep) state_in = S_OSTORE;
         S_OSTORE: state_in = S_PMUL;
         S_PMUL:   state_in = S_PSUM;
         S_PSUM:   state_in = S_HINIT;
         S_HINIT:  state_in = S_HRUN;
         S_HRUN:   if (step_ff == LastStep) state_in = S_OUT;
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op   = OP_NONE;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) cmd.op = OP_LOAD;
         S_PROD:   cmd.op = OP_PROD;
         S_VINIT:  cmd.op = OP_VEC_INIT;
         S_VRUN:   cmd.op = OP_STEP;
         S_YAW:    cmd.op = OP_YAW;
         S_OINIT:  cmd.op = OP_ORG_INIT;
         S_ORUN:   cmd.op = OP_STEP;
         S_OSTORE: cmd.op = OP_ORG_STORE;
         S_PMUL:   cmd.op = OP_POS_MUL;
         S_PSUM:   cmd.op = OP_POS_SUM;
         S_HINIT:  cmd.op = OP_HALF_INIT;
         S_HRUN:   cmd.op = OP_STEP;
         S_OUT:    if (out_free) cmd.op = OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // step counter and result valid
   always_comb begin
      step_in = '0;
      if (state_ff == S_VRUN || state_ff == S_ORUN || state_ff == S_HRUN) begin
         step_in = (step_ff == LastStep) ? '0 : step_ff + 1'b1;
      end
      valid_in = (valid_ff && !rsp_tready) || (state_ff == S_OUT && out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ design/prbase_dp.sv @@
module prbase_dp import prbase_pkg::*; #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [159:0]  req_tdata,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic [127:0]  rsp_tdata
);

   localparam int AW = ANGLE_WIDTH;

   // input transaction
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   // quaternion products
   logic signed [31:0] p0_ff, p1_ff, p2_ff, p3_ff;
   // shared CORDIC
   logic signed [39:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic               vec_ff, vec_in, neg_ff, neg_in, zero_ff;
   logic [AW-1:0]      yaw_ff;
   // origin
   logic               cap_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic [AW-1:0]      oyaw_ff;
   logic signed [15:0] ocos_ff, osin_ff;
   // position products and results
   logic signed [48:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   // output register, held while the result waits
   logic signed [31:0] orx_ff, ory_ff, orz_ff;
   logic signed [15:0] oqz_ff, oqw_ff;

   logic signed [35:0] num, den;
   logic signed [39:0] xs, ys, vx, vy;
   logic signed [39:0] at;
   logic               up;
   logic signed [33:0] z0, zf;
   logic               fold_neg;
   logic [31:0]        yaw_acc;
   logic [AW-1:0]      yaw_diff;
   logic signed [32:0] dx, dy, dz;
   logic signed [49:0] sx, sy;
   logic signed [15:0] cos_r, sin_r;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sh7FFFFFFF)        return 32'sh7FFFFFFF;
      else if (v < -50'sh80000000)  return 32'sh80000000;
      else                          return v[31:0];
   endfunction

   // round Q2.30 to Q2.14 and clamp to plus or minus one
   function automatic logic signed [15:0] to_q14(input logic signed [39:0] v);
      logic signed [39:0] r;
      r = (v + 40'sd32768) >>> 16;
      if (r > 40'sd16384)       return Q14One;
      else if (r < -40'sd16384) return -Q14One;
      else                      return r[15:0];
   endfunction

   assign status.captured = cap_ff;
   assign rsp_tdata = {oqw_ff, oqz_ff, orz_ff, ory_ff, orx_ff};

   // atan2 operands
   assign num = 36'(2) * (36'(p0_ff) + 36'(p1_ff));
   assign den = 36'sh10000000 - 36'(2) * (36'(p2_ff) + 36'(p3_ff));

   // one CORDIC micro-rotation
   always_comb begin
      xs = x_ff >>> cmd.step;
      ys = y_ff >>> cmd.step;
      at = 40'($signed({1'b0, atan_entry(cmd.step)}));
      up = vec_ff ? (y_ff > 0) : (z_ff < 0);
      vx = num[35] ? -40'(num) : 40'(num);
      vy = den[35] ? -40'(den) : 40'(den);
   end

   // rotation start angle with fold into plus or minus a quarter turn
   always_comb begin
      yaw_diff = yaw_ff - oyaw_ff;
      if (cmd.op == OP_ORG_INIT) z0 = {{2{yaw_ff[AW-1]}}, yaw_ff, {(32-AW){1'b0}}};
      else z0 = {{(34-AW){yaw_diff[AW-1]}}, yaw_diff} <<< (31 - AW);
      zf       = z0;
      fold_neg = 1'b0;
      if (z0 > 34'sh40000000) begin
         zf = z0 - 34'sh80000000; fold_neg = 1'b1;
      end else if (z0 < -34'sh40000000) begin
         zf = z0 + 34'sh80000000; fold_neg = 1'b1;
      end
      yaw_acc = z_ff[31:0] + (32'd1 << (31 - AW));
      cos_r = to_q14(neg_ff ? -x_ff : x_ff);
      sin_r = to_q14(neg_ff ? -y_ff : y_ff);
      dx = 33'(px_ff) - 33'(ox_ff);
      dy = 33'(py_ff) - 33'(oy_ff);
      dz = 33'(pz_ff) - 33'(oz_ff);
      sx = 50'(m0_ff) + 50'(m1_ff) + 50'sd8192;
      sy = 50'(m2_ff) - 50'(m3_ff) + 50'sd8192;
   end

   // CORDIC register update
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; vec_in = vec_ff; neg_in = neg_ff;
      case (cmd.op)
         OP_VEC_INIT: begin
            vec_in = 1'b1;
            x_in   = 40'(den);
            y_in   = 40'(num);
            z_in   = '0;
            if (den < 0) begin
               x_in = -40'(den); y_in = -40'(num); z_in = 34'sh080000000;
            end
         end
         OP_ORG_INIT, OP_HALF_INIT: begin
            vec_in = 1'b0;
            x_in   = CordicGain;
            y_in   = '0;
            z_in   = zf;
            neg_in = fold_neg;
         end
         OP_STEP: begin
            if (up) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + 34'(at);
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - 34'(at);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; vec_ff <= vec_in; neg_ff <= neg_in;
      case (cmd.op)
         OP_LOAD: begin
            px_ff <= req_tdata[31:0];    py_ff <= req_tdata[63:32];
            pz_ff <= req_tdata[95:64];   qw_ff <= req_tdata[111:96];
            qx_ff <= req_tdata[127:112]; qy_ff <= req_tdata[143:128];
            qz_ff <= req_tdata[159:144];
         end
         OP_PROD: begin
            p0_ff <= qw_ff * qz_ff; p1_ff <= qx_ff * qy_ff;
            p2_ff <= qy_ff * qy_ff; p3_ff <= qz_ff * qz_ff;
         end
         OP_VEC_INIT: zero_ff <= (vx == 0) && (vy == 0);
         OP_YAW:      yaw_ff <= zero_ff ? '0 : yaw_acc[31 -: AW];
         OP_POS_MUL: begin
            m0_ff <= dx * ocos_ff; m1_ff <= dy * osin_ff;
            m2_ff <= dy * ocos_ff; m3_ff <= dx * osin_ff;
            rz_ff <= sat32(50'(dz));
         end
         OP_POS_SUM: begin
            rx_ff <= sat32(sx >>> 14);
            ry_ff <= sat32(sy >>> 14);
         end
         OP_OUT: begin
            orx_ff <= rx_ff;
            ory_ff <= ry_ff;
            orz_ff <= rz_ff;
            oqw_ff <= cos_r;
            oqz_ff <= sin_r;
         end
         default: ;
      endcase
   end

   // origin registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0; ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         oyaw_ff <= '0; ocos_ff <= Q14One; osin_ff <= '0;
      end else if (cmd.op == OP_ORG_STORE) begin
         cap_ff <= 1'b1; ox_ff <= px_ff; oy_ff <= py_ff; oz_ff <= pz_ff;
         oyaw_ff <= yaw_ff; ocos_ff <= cos_r; osin_ff <= sin_r;
      end
   end

endmodule

@@ design/pose_rebase_to_initial_frame_top.sv @@
// Rebases each pose to the first pose seen after reset. Yaw comes from a
// CORDIC in vectoring mode; the first pose fixes the origin position and
// yaw. Output position is the offset rotated by minus the origin yaw (z is
// offset only), and orientation is the half-angle yaw quaternion.
// Each transaction runs the vectoring pass and then the half-angle rotation
// pass (the first after reset also runs the origin cos/sin pass between
// them), all on the single shared CORDIC stage iterating one step per cycle;
// a new request is taken only once the previous one has left the datapath.
// A finished result waits in the output register while the next request is
// taken; that request stalls at its end until the result is read.
module pose_rebase_to_initial_frame_top import prbase_pkg::*; #(
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rel_x, rel_y, rel_z, out_quat_z, out_quat_w
   output logic [127:0] rsp_tdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   prbase_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   prbase_dp #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_dp (
      .clock, .reset, .req_tdata, .cmd, .status, .rsp_tdata
   );

   // one transaction in flight
   a_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a new result only appears while a transaction is in work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without transaction");

   // origin once captured stays
   a_origin: assert property (@(posedge clock) disable iff (reset)
      status.captured |=> status.captured)
      else $error("origin lost");

endmodule
